// File: sv/mva_pkg.sv
// Shared constants, codes and control types for the MIDI voice allocator bridge.
package mva_pkg;

    localparam int VOICE_COUNT = 6;
    localparam int VIDX_W      = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;
    localparam int BUF_DEPTH   = 8;
    localparam int POS_W       = 3;
    localparam int CNT_W       = 4;

    localparam logic [7:0] MIDI_NOTE_ON  = 8'h90;
    localparam logic [7:0] MIDI_NOTE_OFF = 8'h80;
    localparam logic [7:0] MIDI_CTRL     = 8'hB0;
    localparam logic [7:0] MIDI_BEND     = 8'hE0;

    localparam logic [7:0] BUS_LOWER_SEL = 8'hF9;
    localparam logic [7:0] BUS_UPPER_SEL = 8'hF1;
    localparam logic [7:0] BUS_CTRL_SEL  = 8'hF4;
    localparam logic [3:0] BUS_VOICE_ON  = 4'hC;
    localparam logic [3:0] BUS_VOICE_OFF = 4'hD;
    localparam logic [7:0] BUS_SUSTAIN   = 8'hBB;
    localparam logic [7:0] BUS_MOD       = 8'hBC;
    localparam logic [7:0] BUS_BEND_MAG  = 8'hB2;
    localparam logic [7:0] BUS_BEND_POL  = 8'hBF;
    localparam logic [7:0] BUS_POL_UP    = 8'h7F;
    localparam logic [7:0] SEL_NONE      = 8'h00;

    localparam logic [6:0] CC_SUSTAIN    = 7'h40;
    localparam logic [6:0] CC_MOD        = 7'h01;
    localparam logic [6:0] BEND_CENTER   = 7'h40;
    localparam logic [7:0] NOTE_NONE     = 8'hFF;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_NOTE_ON,
        OP_NOTE_OFF,
        OP_CTRL,
        OP_BEND
    } op_t;

    typedef struct packed {
        logic load;
        logic scan_step;
        logic commit;
        logic advance;
    } cmd_t;

    typedef struct packed {
        op_t  in_op;
        op_t  op;
        logic scan_done;
        logic release_ok;
        logic emit_last;
    } stat_t;

endpackage

// File: sv/mva_voice_table.sv
// One voice table with a voice-per-cycle scan for free, oldest and matching voices.
module mva_voice_table (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [31:0]                 start_time,
    input  logic                        step,
    input  logic [mva_pkg::VIDX_W-1:0]  step_idx,
    input  logic [6:0]                  note,
    input  logic                        claim,
    input  logic [31:0]                 claim_time,
    input  logic                        rel_en,
    output logic [mva_pkg::VIDX_W-1:0]  pick_idx,
    output logic                        hit,
    output logic [mva_pkg::VIDX_W-1:0]  hit_idx
);

    logic                       active_reg [mva_pkg::VOICE_COUNT];
    logic [7:0]                 held_reg   [mva_pkg::VOICE_COUNT];
    logic [31:0]                time_reg   [mva_pkg::VOICE_COUNT];

    logic                       free_found_reg;
    logic [mva_pkg::VIDX_W-1:0] free_idx_reg;
    logic [mva_pkg::VIDX_W-1:0] best_idx_reg;
    logic [31:0]                oldest_reg;
    logic                       hit_reg;
    logic [mva_pkg::VIDX_W-1:0] hit_idx_reg;

    assign pick_idx = free_found_reg ? free_idx_reg : best_idx_reg;
    assign hit      = hit_reg;
    assign hit_idx  = hit_idx_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            free_found_reg <= 1'b0;
            hit_reg        <= 1'b0;
            free_idx_reg   <= '0;
            best_idx_reg   <= '0;
            hit_idx_reg    <= '0;
            oldest_reg     <= '0;
        end else if (start) begin
            free_found_reg <= 1'b0;
            hit_reg        <= 1'b0;
            best_idx_reg   <= '0;
            oldest_reg     <= start_time;
        end else if (step) begin
            if (!free_found_reg && !active_reg[step_idx]) begin
                free_found_reg <= 1'b1;
                free_idx_reg   <= step_idx;
            end
            if (time_reg[step_idx] < oldest_reg) begin
                oldest_reg   <= time_reg[step_idx];
                best_idx_reg <= step_idx;
            end
            if (!hit_reg && held_reg[step_idx] == {1'b0, note}) begin
                hit_reg     <= 1'b1;
                hit_idx_reg <= step_idx;
            end
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < mva_pkg::VOICE_COUNT; i++) begin
            if (!aresetn) begin
                active_reg[i] <= 1'b0;
                held_reg[i]   <= mva_pkg::NOTE_NONE;
                time_reg[i]   <= '0;
            end else if (claim && pick_idx == mva_pkg::VIDX_W'(i)) begin
                active_reg[i] <= 1'b1;
                held_reg[i]   <= {1'b0, note};
                time_reg[i]   <= claim_time;
            end else if (rel_en && hit_idx_reg == mva_pkg::VIDX_W'(i)) begin
                active_reg[i] <= 1'b0;
            end
        end
    end

endmodule

// File: sv/mva_datapath.sv
// Datapath: message capture, both voice tables, select tracking and the output byte buffer.
module mva_datapath (
    input  logic                aclk,
    input  logic                aresetn,
    input  mva_pkg::cmd_t       cmd,
    output mva_pkg::stat_t      stat,
    input  logic [7:0]          s_status_byte,
    input  logic [6:0]          s_data_first,
    input  logic [6:0]          s_data_second,
    input  logic [31:0]         s_now_time,
    output logic [7:0]          m_bus_byte,
    output logic                m_last_byte
);

    mva_pkg::op_t               in_op;
    mva_pkg::op_t               op_reg;
    logic [6:0]                 note_reg;
    logic [6:0]                 vel_reg;
    logic [31:0]                now_reg;
    logic [7:0]                 sel_reg;
    logic [mva_pkg::VIDX_W-1:0] idx_reg;
    logic [7:0]                 buf_reg [mva_pkg::BUF_DEPTH];
    logic [mva_pkg::POS_W-1:0]  pos_reg;
    logic [mva_pkg::CNT_W-1:0]  count_reg;

    logic [mva_pkg::VIDX_W-1:0] up_pick, lo_pick, up_hit_idx, lo_hit_idx;
    logic                       up_hit, lo_hit;
    logic                       table_start, table_claim, table_rel;
    logic                       release_ok, skip_sel;
    logic [7:0]                 ctl_byte, mag_byte, pol_byte;
    logic [6:0]                 mag;
    logic [3:0]                 voice_code;

    always_comb begin
        case (s_status_byte)
            mva_pkg::MIDI_NOTE_ON:  in_op = mva_pkg::OP_NOTE_ON;
            mva_pkg::MIDI_NOTE_OFF: in_op = mva_pkg::OP_NOTE_OFF;
            mva_pkg::MIDI_CTRL:     in_op = mva_pkg::OP_CTRL;
            mva_pkg::MIDI_BEND:     in_op = mva_pkg::OP_BEND;
            default:                in_op = mva_pkg::OP_NONE;
        endcase
    end

    always_comb begin
        if (s_data_first == mva_pkg::CC_SUSTAIN) begin
            ctl_byte = mva_pkg::BUS_SUSTAIN;
        end else if (s_data_first == mva_pkg::CC_MOD) begin
            ctl_byte = mva_pkg::BUS_MOD;
        end else begin
            ctl_byte = {1'b0, s_data_first};
        end
        mag      = (s_data_second >= mva_pkg::BEND_CENTER) ? s_data_second - mva_pkg::BEND_CENTER
                                                          : mva_pkg::BEND_CENTER - s_data_second;
        mag_byte = {mag, 1'b0};
        pol_byte = (s_data_second > mva_pkg::BEND_CENTER) ? mva_pkg::BUS_POL_UP : 8'h00;
    end

    assign skip_sel    = (sel_reg == mva_pkg::BUS_CTRL_SEL);
    assign release_ok  = up_hit && lo_hit;
    assign table_start = cmd.load;
    assign table_claim = cmd.commit && op_reg == mva_pkg::OP_NOTE_ON;
    assign table_rel   = cmd.commit && op_reg == mva_pkg::OP_NOTE_OFF && release_ok;
    assign voice_code  = (op_reg == mva_pkg::OP_NOTE_ON) ? mva_pkg::BUS_VOICE_ON
                                                          : mva_pkg::BUS_VOICE_OFF;

    mva_voice_table u_upper (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .start      (table_start),
        .start_time (s_now_time),
        .step       (cmd.scan_step),
        .step_idx   (idx_reg),
        .note       (note_reg),
        .claim      (table_claim),
        .claim_time (now_reg),
        .rel_en     (table_rel),
        .pick_idx   (up_pick),
        .hit        (up_hit),
        .hit_idx    (up_hit_idx)
    );

    mva_voice_table u_lower (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .start      (table_start),
        .start_time (s_now_time),
        .step       (cmd.scan_step),
        .step_idx   (idx_reg),
        .note       (note_reg),
        .claim      (table_claim),
        .claim_time (now_reg),
        .rel_en     (table_rel),
        .pick_idx   (lo_pick),
        .hit        (lo_hit),
        .hit_idx    (lo_hit_idx)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            op_reg    <= mva_pkg::OP_NONE;
            sel_reg   <= mva_pkg::SEL_NONE;
            idx_reg   <= '0;
            pos_reg   <= '0;
            count_reg <= '0;
        end else if (cmd.load) begin
            op_reg   <= in_op;
            note_reg <= s_data_first;
            vel_reg  <= s_data_second;
            now_reg  <= s_now_time;
            idx_reg  <= '0;
            pos_reg  <= skip_sel ? mva_pkg::POS_W'(1) : '0;
            if (in_op == mva_pkg::OP_CTRL) begin
                buf_reg[0] <= mva_pkg::BUS_CTRL_SEL;
                buf_reg[1] <= ctl_byte;
                buf_reg[2] <= {1'b0, s_data_second};
                count_reg  <= mva_pkg::CNT_W'(3);
                sel_reg    <= mva_pkg::BUS_CTRL_SEL;
            end else if (in_op == mva_pkg::OP_BEND) begin
                buf_reg[0] <= mva_pkg::BUS_CTRL_SEL;
                buf_reg[1] <= mva_pkg::BUS_BEND_MAG;
                buf_reg[2] <= mag_byte;
                buf_reg[3] <= mva_pkg::BUS_BEND_POL;
                buf_reg[4] <= pol_byte;
                count_reg  <= mva_pkg::CNT_W'(5);
                sel_reg    <= mva_pkg::BUS_CTRL_SEL;
            end
        end else if (cmd.scan_step) begin
            idx_reg <= idx_reg + mva_pkg::VIDX_W'(1);
        end else if (cmd.commit) begin
            buf_reg[0] <= mva_pkg::BUS_LOWER_SEL;
            buf_reg[1] <= {voice_code,
                           (op_reg == mva_pkg::OP_NOTE_ON) ? 4'(lo_pick) : 4'(lo_hit_idx)};
            buf_reg[2] <= {1'b0, note_reg};
            buf_reg[3] <= {1'b0, vel_reg};
            buf_reg[4] <= mva_pkg::BUS_UPPER_SEL;
            buf_reg[5] <= {voice_code,
                           (op_reg == mva_pkg::OP_NOTE_ON) ? 4'(up_pick) : 4'(up_hit_idx)};
            buf_reg[6] <= {1'b0, note_reg};
            buf_reg[7] <= {1'b0, vel_reg};
            count_reg  <= mva_pkg::CNT_W'(8);
            pos_reg    <= '0;
            if (op_reg == mva_pkg::OP_NOTE_ON || release_ok) begin
                sel_reg <= mva_pkg::SEL_NONE;
            end
        end else if (cmd.advance) begin
            pos_reg <= pos_reg + mva_pkg::POS_W'(1);
        end
    end

    assign m_bus_byte  = buf_reg[pos_reg];
    assign m_last_byte = ({1'b0, pos_reg} == count_reg - mva_pkg::CNT_W'(1));

    assign stat.in_op      = in_op;
    assign stat.op         = op_reg;
    assign stat.scan_done  = (idx_reg == mva_pkg::VIDX_W'(mva_pkg::VOICE_COUNT - 1));
    assign stat.release_ok = release_ok;
    assign stat.emit_last  = m_last_byte;

endmodule

// File: sv/mva_ctrl.sv
// Controller state machine: accept, voice scan, table update and byte output.
module mva_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    output logic            m_valid,
    input  logic            m_ready,
    input  mva_pkg::stat_t  stat,
    output mva_pkg::cmd_t   cmd
);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_SCAN   = 4'b0010,
        ST_COMMIT = 4'b0100,
        ST_EMIT   = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = (state_reg == ST_EMIT);

    always_comb begin
        state_next    = state_reg;
        cmd           = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load = 1'b1;
                    case (stat.in_op)
                        mva_pkg::OP_NOTE_ON, mva_pkg::OP_NOTE_OFF: state_next = ST_SCAN;
                        mva_pkg::OP_CTRL, mva_pkg::OP_BEND:        state_next = ST_EMIT;
                        default:                                   state_next = ST_IDLE;
                    endcase
                end
            end
            ST_SCAN: begin
                cmd.scan_step = 1'b1;
                if (stat.scan_done) begin
                    state_next = ST_COMMIT;
                end
            end
            ST_COMMIT: begin
                cmd.commit = 1'b1;
                if (stat.op == mva_pkg::OP_NOTE_ON || stat.release_ok) begin
                    state_next = ST_EMIT;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_EMIT: begin
                if (m_ready) begin
                    cmd.advance = 1'b1;
                    if (stat.emit_last) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// File: sv/midi_voice_allocator_bridge.sv
// Top level of the MIDI voice allocator bridge.
// Takes one channel-1 MIDI message per item and sends the synth bus bytes one item per
// cycle while m_ready is high, with m_last_byte on the final one. One message is handled
// at a time. A note-on or note-off scans both voice tables in parallel, one voice per
// cycle, then updates them in the commit state before the eight bytes go out. Control
// change and pitch bend skip the scan and send 2 to 5 output bytes. Other messages, and a
// note-off whose note is not held in both tables, produce no bytes.
module midi_voice_allocator_bridge (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_status_byte,
    input  logic [6:0]  s_data_first,
    input  logic [6:0]  s_data_second,
    input  logic [31:0] s_now_time,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_bus_byte,
    output logic        m_last_byte
);

    mva_pkg::cmd_t  cmd;
    mva_pkg::stat_t stat;

    mva_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    mva_datapath u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .stat          (stat),
        .s_status_byte (s_status_byte),
        .s_data_first  (s_data_first),
        .s_data_second (s_data_second),
        .s_now_time    (s_now_time),
        .m_bus_byte    (m_bus_byte),
        .m_last_byte   (m_last_byte)
    );

endmodule
